// ===== src/bpc_pkg.sv =====
// ----------------------------------------------------------------------------
// bpc_pkg: shared types and constants of the bracket pair checker
// Word formats of the input, result and op queues, lexer modes, character
// codes and error kinds.
// ----------------------------------------------------------------------------
package bpc_pkg;

  // Input word: one text byte or the end-of-text marker
  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_word_t;

  // Result word: first-error report or end-of-text verdict
  typedef struct packed {
    logic        is_verdict;
    logic        passed;
    logic [2:0]  error_kind;
    logic [7:0]  reported_char;
    logic [23:0] error_line;
    logic [15:0] error_column;
  } out_word_t;

  // Lexer modes
  typedef enum logic [2:0] {
    MODE_NORMAL,
    MODE_DQUOTE,
    MODE_SQUOTE,
    MODE_LINE,
    MODE_BLOCK,
    MODE_SLASH
  } lex_mode_t;

  // Bracket codes as kept on the stack
  typedef enum logic [1:0] {
    BR_PAREN,
    BR_SQUARE,
    BR_CURLY
  } br_code_t;

  // Ops handed from the lexer to the stack unit
  typedef enum logic [1:0] {
    OP_PUSH,
    OP_POP,
    OP_END
  } op_kind_t;

  typedef struct packed {
    op_kind_t    kind;
    br_code_t    code;
    logic [23:0] line;
    logic [15:0] column;
  } op_word_t;

  // Op queue size
  localparam int OPQ_DEPTH = 4;
  localparam int OPQ_AW    = 2;
  localparam int OPQ_CW    = 3;

  // Error kinds
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_MISMATCH = 3'd1;
  localparam logic [2:0] ERR_EMPTY    = 3'd2;
  localparam logic [2:0] ERR_UNCLOSED = 3'd3;
  localparam logic [2:0] ERR_OVERFLOW = 3'd4;

  // Character codes
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_LSQUARE = 8'h5B;
  localparam logic [7:0] CH_RSQUARE = 8'h5D;
  localparam logic [7:0] CH_LCURLY  = 8'h7B;
  localparam logic [7:0] CH_RCURLY  = 8'h7D;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  // Counter limits
  localparam logic [23:0] LINE_MAX = 24'hFFFFFF;
  localparam logic [15:0] COL_MAX  = 16'hFFFF;

  function automatic logic [7:0] opener_char(input br_code_t code);
    logic [7:0] ch;
    unique case (code)
      BR_PAREN:  ch = CH_LPAREN;
      BR_SQUARE: ch = CH_LSQUARE;
      BR_CURLY:  ch = CH_LCURLY;
      default:   ch = CH_NUL;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] closer_char(input br_code_t code);
    logic [7:0] ch;
    unique case (code)
      BR_PAREN:  ch = CH_RPAREN;
      BR_SQUARE: ch = CH_RSQUARE;
      BR_CURLY:  ch = CH_RCURLY;
      default:   ch = CH_NUL;
    endcase
    return ch;
  endfunction

endpackage

// ===== src/bracket_pair_checker.sv =====
// ----------------------------------------------------------------------------
// bracket_pair_checker: balanced bracket checker for C source text
// Input side is a queue (push/full), result side is a queue (empty/pop).
// Each input word is one text byte, or an end-of-text marker.
// A result word is a first-error report or, at end of text, the verdict.
// Throughput: one input word per cycle while full is low. The lexer decodes
// a byte combinationally; bracket and end words go through a 4-entry op
// queue to the stack unit, which runs one op per cycle while the result
// register can take what it makes, with the top of stack in a register and
// the entry below it read ahead from the stack memory. With the op queue
// empty, an accepted bracket or end word is written to the op queue, then
// the stack unit runs it and puts its result in the result register for pop.
// When pop is held low with a result waiting, the stack unit stops, the op
// queue fills and full rises; bytes that make no op still pass meanwhile
// until then. Reset (rst, synchronous) clears mode, counters, stack count
// and error state; the stack memory itself is not cleared.
// ----------------------------------------------------------------------------
module bracket_pair_checker #(
  parameter int STACK_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  bpc_pkg::in_word_t  item,
  output logic               empty,
  input  logic               pop,
  output bpc_pkg::out_word_t result
);
  import bpc_pkg::*;

  logic      in_valid;
  logic      op_valid_f, op_valid_b, op_take;
  op_word_t  op_word_f, op_word_b;
  logic      res_valid;

  assign in_valid = push && !full;
  assign empty    = !res_valid;

  // Front end: lexer
  bpc_lexer u_lexer (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_word  (item),
    .op_valid (op_valid_f),
    .op_word  (op_word_f)
  );

  // Op queue between front and back
  bpc_op_queue u_op_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (op_valid_f),
    .wr_word  (op_word_f),
    .rd_en    (op_take),
    .rd_valid (op_valid_b),
    .rd_word  (op_word_b),
    .full     (full)
  );

  // Back end: stack unit and result register
  bpc_stack_unit #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack_unit (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (op_valid_b),
    .op_word   (op_word_b),
    .op_take   (op_take),
    .res_valid (res_valid),
    .res_word  (result),
    .res_take  (pop)
  );

endmodule

// ===== src/bpc_lexer.sv =====
// ----------------------------------------------------------------------------
// bpc_lexer: front end of the bracket pair checker
// Tracks line and column, skips strings and comments, and turns brackets in
// normal code and the end-of-text marker into ops for the stack unit.
// ----------------------------------------------------------------------------
module bpc_lexer (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  bpc_pkg::in_word_t  in_word,
  output logic               op_valid,
  output bpc_pkg::op_word_t  op_word
);
  import bpc_pkg::*;

  lex_mode_t   mode, mode_next;
  logic        esc, esc_next;
  logic        star, star_next;
  logic [23:0] line, line_next;
  logic [15:0] column, column_next;

  logic [7:0]  ch;
  logic [23:0] line_cnt;
  logic [15:0] col_base, col_cnt;
  logic        is_open, is_close;
  br_code_t    br_code;
  logic        as_normal;
  lex_mode_t   nrm_mode;
  logic        nrm_esc_clr;

  assign ch = in_word.text_byte;

  // Counters after this byte, saturating
  always_comb begin
    line_cnt = line;
    col_base = column;
    if (ch == CH_NEWLINE) begin
      col_base = '0;
      if (line != LINE_MAX) line_cnt = line + 24'd1;
    end
    col_cnt = (col_base != COL_MAX) ? col_base + 16'd1 : col_base;
  end

  // Bracket classification
  always_comb begin
    is_open  = 1'b0;
    is_close = 1'b0;
    br_code  = BR_PAREN;
    unique case (ch)
      CH_LPAREN:  is_open  = 1'b1;
      CH_LSQUARE: begin is_open = 1'b1; br_code = BR_SQUARE; end
      CH_LCURLY:  begin is_open = 1'b1; br_code = BR_CURLY; end
      CH_RPAREN:  is_close = 1'b1;
      CH_RSQUARE: begin is_close = 1'b1; br_code = BR_SQUARE; end
      CH_RCURLY:  begin is_close = 1'b1; br_code = BR_CURLY; end
      default:    ;
    endcase
  end

  // Mode change of a byte handled as normal code
  always_comb begin
    nrm_mode    = MODE_NORMAL;
    nrm_esc_clr = 1'b0;
    unique case (ch)
      CH_DQUOTE: begin nrm_mode = MODE_DQUOTE; nrm_esc_clr = 1'b1; end
      CH_SQUOTE: begin nrm_mode = MODE_SQUOTE; nrm_esc_clr = 1'b1; end
      CH_SLASH:  nrm_mode = MODE_SLASH;
      default:   ;
    endcase
  end

  // A byte after a lone slash falls back to normal code
  assign as_normal = (mode == MODE_NORMAL) ||
                     ((mode == MODE_SLASH) && (ch != CH_STAR) && (ch != CH_SLASH));

  // Next state
  always_comb begin
    mode_next   = mode;
    esc_next    = esc;
    star_next   = star;
    line_next   = line;
    column_next = column;
    if (in_valid) begin
      if (in_word.end_of_text) begin
        mode_next   = MODE_NORMAL;
        esc_next    = 1'b0;
        star_next   = 1'b0;
        line_next   = 24'd1;
        column_next = '0;
      end else begin
        line_next   = line_cnt;
        column_next = col_cnt;
        unique case (mode)
          MODE_DQUOTE, MODE_SQUOTE: begin
            if (ch == CH_BSLASH) begin
              esc_next = !esc;
            end else begin
              if (!esc && (((mode == MODE_DQUOTE) && (ch == CH_DQUOTE)) ||
                           ((mode == MODE_SQUOTE) && (ch == CH_SQUOTE))))
                mode_next = MODE_NORMAL;
              esc_next = 1'b0;
            end
          end
          MODE_LINE: begin
            if (ch == CH_NEWLINE) mode_next = MODE_NORMAL;
          end
          MODE_BLOCK: begin
            if ((ch == CH_SLASH) && star) mode_next = MODE_NORMAL;
            star_next = (ch == CH_STAR);
          end
          MODE_SLASH, MODE_NORMAL: begin
            if ((mode == MODE_SLASH) && (ch == CH_STAR)) begin
              mode_next = MODE_BLOCK;
              star_next = 1'b0;
            end else if ((mode == MODE_SLASH) && (ch == CH_SLASH)) begin
              mode_next = MODE_LINE;
            end else begin
              mode_next = nrm_mode;
              if (nrm_esc_clr) esc_next = 1'b0;
            end
          end
          default: mode_next = MODE_NORMAL;
        endcase
      end
    end
  end

  // Op output
  always_comb begin
    op_valid       = in_valid &&
                     (in_word.end_of_text || (as_normal && (is_open || is_close)));
    op_word.code   = br_code;
    op_word.kind   = in_word.end_of_text ? OP_END : (is_open ? OP_PUSH : OP_POP);
    op_word.line   = in_word.end_of_text ? line : line_cnt;
    op_word.column = in_word.end_of_text ? column : col_cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_NORMAL;
      esc    <= 1'b0;
      star   <= 1'b0;
      line   <= 24'd1;
      column <= '0;
    end else begin
      mode   <= mode_next;
      esc    <= esc_next;
      star   <= star_next;
      line   <= line_next;
      column <= column_next;
    end
  end

endmodule

// ===== src/bpc_op_queue.sv =====
// ----------------------------------------------------------------------------
// bpc_op_queue: short queue of ops between lexer and stack unit
// Register queue; full and not-empty come straight from the fill count.
// ----------------------------------------------------------------------------
module bpc_op_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  bpc_pkg::op_word_t  wr_word,
  input  logic               rd_en,
  output logic               rd_valid,
  output bpc_pkg::op_word_t  rd_word,
  output logic               full
);
  import bpc_pkg::*;

  op_word_t             slots [OPQ_DEPTH];
  logic [OPQ_AW-1:0]    wr_ptr, rd_ptr;
  logic [OPQ_CW-1:0]    fill;

  assign rd_valid = (fill != '0);
  assign full     = (fill == OPQ_CW'(OPQ_DEPTH));
  assign rd_word  = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (wr_en) slots[wr_ptr] <= wr_word;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) wr_ptr <= wr_ptr + OPQ_AW'(1);
      if (rd_en) rd_ptr <= rd_ptr + OPQ_AW'(1);
      if (wr_en && !rd_en)      fill <= fill + OPQ_CW'(1);
      else if (!wr_en && rd_en) fill <= fill - OPQ_CW'(1);
    end
  end

endmodule

// ===== src/bpc_stack_unit.sv =====
// ----------------------------------------------------------------------------
// bpc_stack_unit: back end of the bracket pair checker
// Runs push/pop/end ops against the bracket stack, latches the first error
// and drives the result register.
// ----------------------------------------------------------------------------
module bpc_stack_unit #(
  parameter int STACK_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               op_valid,
  input  bpc_pkg::op_word_t  op_word,
  output logic               op_take,
  output logic               res_valid,
  output bpc_pkg::out_word_t res_word,
  input  logic               res_take
);
  import bpc_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  // Stack memory; top entry and the one below it kept in registers
  br_code_t          stack_mem [STACK_DEPTH];
  br_code_t          top, top_next;
  br_code_t          below;
  logic [CW-1:0]     count, count_next;
  logic              wr_en;
  logic [AW-1:0]     rd_addr;

  logic              err_seen, err_seen_next;
  logic [23:0]       err_line;
  logic [15:0]       err_column;
  logic              make_res;
  out_word_t         res;
  logic              fire;

  // Take an op only when the result register can take what it makes
  assign fire    = op_valid && (!res_valid || res_take);
  assign op_take = fire;

  // Op execution
  always_comb begin
    count_next        = count;
    top_next          = top;
    err_seen_next     = err_seen;
    wr_en             = 1'b0;
    make_res          = 1'b0;
    res.is_verdict    = 1'b0;
    res.passed        = 1'b0;
    res.error_kind    = ERR_NONE;
    res.reported_char = CH_NUL;
    res.error_line    = op_word.line;
    res.error_column  = op_word.column;
    if (fire) begin
      unique case (op_word.kind)
        OP_PUSH: begin
          if (!err_seen) begin
            if (count == CW'(STACK_DEPTH)) begin
              err_seen_next     = 1'b1;
              make_res          = 1'b1;
              res.error_kind    = ERR_OVERFLOW;
              res.reported_char = opener_char(op_word.code);
            end else begin
              wr_en      = 1'b1;
              count_next = count + CW'(1);
              top_next   = op_word.code;
            end
          end
        end
        OP_POP: begin
          if (!err_seen) begin
            if (count == '0) begin
              err_seen_next  = 1'b1;
              make_res       = 1'b1;
              res.error_kind = ERR_EMPTY;
            end else begin
              count_next = count - CW'(1);
              top_next   = below;
              if (top != op_word.code) begin
                err_seen_next     = 1'b1;
                make_res          = 1'b1;
                res.error_kind    = ERR_MISMATCH;
                res.reported_char = closer_char(top);
              end
            end
          end
        end
        OP_END: begin
          make_res       = 1'b1;
          res.is_verdict = 1'b1;
          err_seen_next  = 1'b0;
          count_next     = '0;
          if (err_seen) begin
            res.error_line   = err_line;
            res.error_column = err_column;
          end else if (count != '0) begin
            res.error_kind    = ERR_UNCLOSED;
            res.reported_char = opener_char(top);
          end else begin
            res.passed = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Entry below the new top, read ahead for the next pop
  assign rd_addr = AW'(count_next - CW'(2));

  always_ff @(posedge clk) begin
    if (wr_en) stack_mem[count[AW-1:0]] <= op_word.code;
    below <= stack_mem[rd_addr];
    top   <= top_next;
  end

  // Error position, frozen at the first error
  always_ff @(posedge clk) begin
    if (fire && !err_seen && err_seen_next) begin
      err_line   <= op_word.line;
      err_column <= op_word.column;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      err_seen <= 1'b0;
    end else begin
      count    <= count_next;
      err_seen <= err_seen_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (make_res) begin
      res_valid <= 1'b1;
    end else if (res_take) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (make_res) res_word <= res;
  end

endmodule
